// File: rtl/windowed_velocity_smoother_macros.svh
// ----------------------------------------------------------------------------
// Windowed velocity smoother: assertion macros
// Implication checks shared by the controller and the datapath.
// ----------------------------------------------------------------------------
`ifndef WINDOWED_VELOCITY_SMOOTHER_MACROS_SVH
`define WINDOWED_VELOCITY_SMOOTHER_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define WVS_ASSERT_SAME(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define WVS_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// File: rtl/wvs_pkg.sv
// ----------------------------------------------------------------------------
// wvs_pkg
// Field widths, register indexes, reset values and the control/status
// bundles passed between controller and datapath.
// ----------------------------------------------------------------------------
package wvs_pkg;

	localparam int VEL_W    = 16;
	localparam int TIME_W   = 32;
	localparam int WIN_W    = 16;
	localparam int THR_W    = 15;
	localparam int MID_W    = 16;
	localparam int SHAPE_W  = 8;
	localparam int HGT_W    = 10;
	localparam int CFG_W    = 16;
	localparam int CFG_IX_W = 3;

	// stream payload widths
	localparam int IN_DATA_W  = 80;
	localparam int OUT_DATA_W = 96;

	// register indexes
	localparam logic [CFG_IX_W-1:0] REG_WINDOW    = 3'd0;
	localparam logic [CFG_IX_W-1:0] REG_THRESHOLD = 3'd1;
	localparam logic [CFG_IX_W-1:0] REG_MOTION_ID = 3'd2;
	localparam logic [CFG_IX_W-1:0] REG_SHAPE     = 3'd3;
	localparam logic [CFG_IX_W-1:0] REG_HGT_FRONT = 3'd4;
	localparam logic [CFG_IX_W-1:0] REG_HGT_REAR  = 3'd5;

	// register reset values
	localparam logic [WIN_W-1:0]   RST_WINDOW    = 16'd500;
	localparam logic [THR_W-1:0]   RST_THRESHOLD = 15'd5;
	localparam logic [MID_W-1:0]   RST_MOTION_ID = 16'd309;
	localparam logic [SHAPE_W-1:0] RST_SHAPE     = 8'd0;
	localparam logic [HGT_W-1:0]   RST_HGT_FRONT = 10'd60;
	localparam logic [HGT_W-1:0]   RST_HGT_REAR  = 10'd60;

	// controller to datapath
	typedef struct packed {
		logic capture;     // latch the incoming transaction
		logic drop;        // retire the oldest history entry
		logic append;      // write the new sample and add it to the sums
		logic div_start;   // start the three mean divisions
		logic avg_clear;   // zero result for a stop command
		logic avg_latch;   // take the division results
		logic out_load;    // load the output register
	} wvs_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_stop;     // all three magnitudes below threshold
		logic aged;        // oldest entry lies outside the window
		logic full;        // history holds HISTORY_DEPTH entries
		logic div_busy;    // divisions still running
	} wvs_sts_t;

	// magnitude of a velocity, one bit wider so that the most negative value fits
	function automatic logic [VEL_W:0] vel_mag(input logic [VEL_W-1:0] v);
		logic [VEL_W:0] ext;
		ext = {v[VEL_W-1], v};
		return v[VEL_W-1] ? ((VEL_W+1)'(0) - ext) : ext;
	endfunction

endpackage

// File: rtl/wvs_div.sv
// ----------------------------------------------------------------------------
// wvs_div
// Signed sum divided by an unsigned count, truncated toward zero.
// Restoring division, one quotient bit per cycle, SUM_W quotient bits per run.
// ----------------------------------------------------------------------------
module wvs_div #(
	parameter int SUM_W = 23,
	parameter int CNT_W = 7
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [SUM_W-1:0]      dividend,
	input  logic [CNT_W-1:0]      divisor,
	output logic                  busy,
	output logic [wvs_pkg::VEL_W-1:0] quot
);
	import wvs_pkg::*;

	localparam int STEP_W = $clog2(SUM_W + 1);

	logic              busy_q;
	logic [STEP_W-1:0] step_q;
	logic              neg_q;
	logic [SUM_W-1:0]  acc_q;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W-1:0]  den_q;

	logic              dvd_neg;
	logic [SUM_W-1:0]  dvd_mag;
	logic [CNT_W:0]    rem_sh;
	logic              ge;
	logic [CNT_W:0]    rem_nx;
	logic [SUM_W-1:0]  q_signed;

	// operand magnitude and one restoring step
	always_comb begin
		dvd_neg  = dividend[SUM_W-1];
		dvd_mag  = dvd_neg ? (SUM_W'(0) - dividend) : dividend;
		rem_sh   = {rem_q, acc_q[SUM_W-1]};
		ge       = (rem_sh >= {1'b0, den_q});
		rem_nx   = ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
		q_signed = neg_q ? (SUM_W'(0) - acc_q) : acc_q;
	end

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= STEP_W'(SUM_W);
		end else if (busy_q) begin
			step_q <= step_q - STEP_W'(1);
			if (step_q == STEP_W'(1))
				busy_q <= 1'b0;
		end
	end

	// shift register: dividend bits move out, quotient bits move in
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= dvd_mag;
			rem_q <= '0;
			den_q <= divisor;
			neg_q <= dvd_neg;
		end else if (busy_q) begin
			acc_q <= {acc_q[SUM_W-2:0], ge};
			rem_q <= rem_nx[CNT_W-1:0];
		end
	end

	assign busy = busy_q;
	assign quot = q_signed[VEL_W-1:0];

endmodule

// File: rtl/wvs_ctrl.sv
// ----------------------------------------------------------------------------
// wvs_ctrl
// Sequencer for one command: stop check, window pruning walk, append,
// division and hand-off to the output register.
// ----------------------------------------------------------------------------
`include "windowed_velocity_smoother_macros.svh"

module wvs_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  wvs_pkg::wvs_sts_t sts,
	output wvs_pkg::wvs_cmd_t cmd
);
	import wvs_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_CHECK  = 3'd1;
	localparam logic [2:0] S_PRUNE  = 3'd2;
	localparam logic [2:0] S_WAIT   = 3'd3;
	localparam logic [2:0] S_APPEND = 3'd4;
	localparam logic [2:0] S_DIV    = 3'd5;
	localparam logic [2:0] S_DIVW   = 3'd6;
	localparam logic [2:0] S_EMIT   = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_nx;
	logic       stopped_q;
	logic       stopped_nx;
	logic       out_valid_q;
	logic       out_free;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == S_IDLE);

	// next state and commands
	always_comb begin
		state_nx   = state_q;
		stopped_nx = stopped_q;
		cmd        = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_nx    = S_CHECK;
				end
			end
			S_CHECK: begin
				if (sts.is_stop) begin
					if (stopped_q) begin
						state_nx = S_IDLE;
					end else begin
						stopped_nx    = 1'b1;
						cmd.avg_clear = 1'b1;
						state_nx      = S_EMIT;
					end
				end else begin
					stopped_nx = 1'b0;
					state_nx   = S_PRUNE;
				end
			end
			S_PRUNE: begin
				if (sts.aged) begin
					cmd.drop = 1'b1;
					state_nx = S_WAIT;
				end else if (sts.full) begin
					cmd.drop = 1'b1;
					state_nx = S_APPEND;
				end else begin
					state_nx = S_APPEND;
				end
			end
			S_WAIT: begin
				// read port settles on the new oldest entry
				state_nx = S_PRUNE;
			end
			S_APPEND: begin
				cmd.append = 1'b1;
				state_nx   = S_DIV;
			end
			S_DIV: begin
				cmd.div_start = 1'b1;
				state_nx      = S_DIVW;
			end
			S_DIVW: begin
				if (!sts.div_busy) begin
					cmd.avg_latch = 1'b1;
					state_nx      = S_EMIT;
				end
			end
			S_EMIT: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_nx     = S_IDLE;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

	// state, stop flag and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			stopped_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_nx;
			stopped_q <= stopped_nx;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	`WVS_ASSERT_SAME(a_no_overwrite, clk, arst_n, cmd.out_load, out_free, "result overwritten")
	`WVS_ASSERT_NEXT(a_div_runs, clk, arst_n, cmd.div_start, sts.div_busy, "division did not start")
	`WVS_ASSERT_NEXT(a_stop_once, clk, arst_n, (state_q == S_CHECK) && sts.is_stop && stopped_q, state_q == S_IDLE, "repeated stop produced work")

endmodule

// File: rtl/wvs_dp.sv
// ----------------------------------------------------------------------------
// wvs_dp
// Configuration registers, history memory, running sums, division lanes and
// the output register.
// ----------------------------------------------------------------------------
`include "windowed_velocity_smoother_macros.svh"

module wvs_dp #(
	parameter int HISTORY_DEPTH = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [wvs_pkg::CFG_IX_W-1:0]       cfg_index,
	input  logic [wvs_pkg::CFG_W-1:0]          cfg_wdata,
	input  logic [wvs_pkg::IN_DATA_W-1:0]      in_data,
	input  wvs_pkg::wvs_cmd_t                  cmd,
	output wvs_pkg::wvs_sts_t                  sts,
	output logic [wvs_pkg::OUT_DATA_W-1:0]     out_data
);
	import wvs_pkg::*;

	localparam int PTR_W   = $clog2(HISTORY_DEPTH);
	localparam int CNT_W   = $clog2(HISTORY_DEPTH + 1);
	localparam int SUM_W   = VEL_W + CNT_W;
	localparam int ENTRY_W = 3 * VEL_W + TIME_W;
	localparam int PAD_W   = OUT_DATA_W - 4 * VEL_W - SHAPE_W - 2 * HGT_W;
	localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(HISTORY_DEPTH);
	localparam logic [PTR_W:0]   DEPTH_WP = (PTR_W+1)'(HISTORY_DEPTH);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(HISTORY_DEPTH - 1);

	// configuration
	logic [WIN_W-1:0]   window_q;
	logic [THR_W-1:0]   thr_q;
	logic [MID_W-1:0]   mid_q;
	logic [SHAPE_W-1:0] shape_q;
	logic [HGT_W-1:0]   hgt_front_q;
	logic [HGT_W-1:0]   hgt_rear_q;

	// captured transaction
	logic [VEL_W-1:0]  in_x_q;
	logic [VEL_W-1:0]  in_y_q;
	logic [VEL_W-1:0]  in_w_q;
	logic [TIME_W-1:0] in_t_q;

	// history state
	logic [ENTRY_W-1:0] mem [HISTORY_DEPTH];
	logic [ENTRY_W-1:0] rd_q;
	logic [PTR_W-1:0]   oldest_q;
	logic [CNT_W-1:0]   count_q;
	logic [SUM_W-1:0]   sum_x_q;
	logic [SUM_W-1:0]   sum_y_q;
	logic [SUM_W-1:0]   sum_w_q;

	// results
	logic [VEL_W-1:0] avg_x_q;
	logic [VEL_W-1:0] avg_y_q;
	logic [VEL_W-1:0] avg_w_q;
	logic [VEL_W-1:0] quot_x;
	logic [VEL_W-1:0] quot_y;
	logic [VEL_W-1:0] quot_w;
	logic             busy_x;
	logic             busy_y;
	logic             busy_w;
	logic [OUT_DATA_W-1:0] out_q;

	logic [VEL_W-1:0]  rd_x;
	logic [VEL_W-1:0]  rd_y;
	logic [VEL_W-1:0]  rd_w;
	logic [TIME_W-1:0] rd_t;
	logic [TIME_W-1:0] age;
	logic [PTR_W:0]    wp_sum;
	logic [PTR_W-1:0]  wr_ptr;

	assign rd_x = rd_q[VEL_W-1:0];
	assign rd_y = rd_q[2*VEL_W-1:VEL_W];
	assign rd_w = rd_q[3*VEL_W-1:2*VEL_W];
	assign rd_t = rd_q[ENTRY_W-1:3*VEL_W];

	// configuration writes; unknown indexes are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q    <= RST_WINDOW;
			thr_q       <= RST_THRESHOLD;
			mid_q       <= RST_MOTION_ID;
			shape_q     <= RST_SHAPE;
			hgt_front_q <= RST_HGT_FRONT;
			hgt_rear_q  <= RST_HGT_REAR;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WINDOW:    window_q    <= cfg_wdata[WIN_W-1:0];
				REG_THRESHOLD: thr_q       <= cfg_wdata[THR_W-1:0];
				REG_MOTION_ID: mid_q       <= cfg_wdata[MID_W-1:0];
				REG_SHAPE:     shape_q     <= cfg_wdata[SHAPE_W-1:0];
				REG_HGT_FRONT: hgt_front_q <= cfg_wdata[HGT_W-1:0];
				REG_HGT_REAR:  hgt_rear_q  <= cfg_wdata[HGT_W-1:0];
				default: ;
			endcase
		end
	end

	// input capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			in_x_q <= in_data[VEL_W-1:0];
			in_y_q <= in_data[2*VEL_W-1:VEL_W];
			in_w_q <= in_data[3*VEL_W-1:2*VEL_W];
			in_t_q <= in_data[3*VEL_W+TIME_W-1:3*VEL_W];
		end
	end

	// status towards the controller
	always_comb begin
		age          = in_t_q - rd_t;
		sts.is_stop  = (vel_mag(in_x_q) < (VEL_W+1)'(thr_q)) &&
		               (vel_mag(in_y_q) < (VEL_W+1)'(thr_q)) &&
		               (vel_mag(in_w_q) < (VEL_W+1)'(thr_q));
		sts.aged     = (count_q != '0) && (age > TIME_W'(window_q));
		sts.full     = (count_q == DEPTH_C);
		sts.div_busy = busy_x || busy_y || busy_w;
		wp_sum       = (PTR_W+1)'(oldest_q) + (PTR_W+1)'(count_q);
		wr_ptr       = (wp_sum >= DEPTH_WP) ? PTR_W'(wp_sum - DEPTH_WP) : wp_sum[PTR_W-1:0];
	end

	// history ring: one write port, registered read of the oldest entry
	always_ff @(posedge clk) begin
		if (cmd.append)
			mem[wr_ptr] <= {in_t_q, in_w_q, in_y_q, in_x_q};
		rd_q <= mem[oldest_q];
	end

	// ring pointer, fill level and running sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oldest_q <= '0;
			count_q  <= '0;
			sum_x_q  <= '0;
			sum_y_q  <= '0;
			sum_w_q  <= '0;
		end else if (cmd.drop) begin
			oldest_q <= (oldest_q == LAST_PTR) ? '0 : oldest_q + PTR_W'(1);
			count_q  <= count_q - CNT_W'(1);
			sum_x_q  <= sum_x_q - {{(SUM_W-VEL_W){rd_x[VEL_W-1]}}, rd_x};
			sum_y_q  <= sum_y_q - {{(SUM_W-VEL_W){rd_y[VEL_W-1]}}, rd_y};
			sum_w_q  <= sum_w_q - {{(SUM_W-VEL_W){rd_w[VEL_W-1]}}, rd_w};
		end else if (cmd.append) begin
			count_q <= count_q + CNT_W'(1);
			sum_x_q <= sum_x_q + {{(SUM_W-VEL_W){in_x_q[VEL_W-1]}}, in_x_q};
			sum_y_q <= sum_y_q + {{(SUM_W-VEL_W){in_y_q[VEL_W-1]}}, in_y_q};
			sum_w_q <= sum_w_q + {{(SUM_W-VEL_W){in_w_q[VEL_W-1]}}, in_w_q};
		end
	end

	// one division lane per axis
	wvs_div #(.SUM_W(SUM_W), .CNT_W(CNT_W)) u_div_x (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.dividend(sum_x_q), .divisor(count_q), .busy(busy_x), .quot(quot_x)
	);
	wvs_div #(.SUM_W(SUM_W), .CNT_W(CNT_W)) u_div_y (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.dividend(sum_y_q), .divisor(count_q), .busy(busy_y), .quot(quot_y)
	);
	wvs_div #(.SUM_W(SUM_W), .CNT_W(CNT_W)) u_div_w (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.dividend(sum_w_q), .divisor(count_q), .busy(busy_w), .quot(quot_w)
	);

	// means, zero on a stop command
	always_ff @(posedge clk) begin
		if (cmd.avg_clear) begin
			avg_x_q <= '0;
			avg_y_q <= '0;
			avg_w_q <= '0;
		end else if (cmd.avg_latch) begin
			avg_x_q <= quot_x;
			avg_y_q <= quot_y;
			avg_w_q <= quot_w;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.out_load)
			out_q <= {{PAD_W{1'b0}}, hgt_rear_q, hgt_front_q, shape_q, mid_q,
			          avg_w_q, avg_y_q, avg_x_q};
	end

	assign out_data = out_q;

	`WVS_ASSERT_SAME(a_count_range, clk, arst_n, 1'b1, count_q <= DEPTH_C, "fill level beyond history depth")
	`WVS_ASSERT_SAME(a_drop_nonempty, clk, arst_n, cmd.drop, count_q != '0, "entry retired from empty history")
	`WVS_ASSERT_SAME(a_append_room, clk, arst_n, cmd.append, count_q != DEPTH_C, "sample appended to full history")

endmodule

// File: rtl/windowed_velocity_smoother.sv
// ----------------------------------------------------------------------------
// windowed_velocity_smoother
// Time-window moving average of velocity commands with stop detection and
// pass-through of the gait settings.
//
//   channel   dir  handshake              payload
//   s_axis    in   tvalid / tready        lin_x, lin_y, yaw_rate, time_ms
//   m_axis    out  tvalid / tready        means and gait settings
//   cfg       in   cfg_we                 cfg_index, cfg_wdata
//
// A moving command passes through the sequencing states and the bit-serial
// dividers of width SUM_W (16 + bits of the entry count, 23 at depth 64);
// each entry dropped for age adds a wait state for the single memory read
// port; evicting from a full history adds none.
// A stop command skips pruning and division; a repeated stop gives no output.
// Reset clears the fill level, sums and stop flag; history contents are not
// cleared and no clearing pass is needed.
// A stalled output holds the finished result; the next command is taken
// meanwhile and waits at the output stage only if it is done first.
// ----------------------------------------------------------------------------
module windowed_velocity_smoother #(
	parameter int HISTORY_DEPTH = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// lin_x [15:0], lin_y [31:16], yaw_rate [47:32], time_ms [79:48]
	input  logic [wvs_pkg::IN_DATA_W-1:0]     s_axis_tdata,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// avg_x [15:0], avg_y [31:16], avg_yaw [47:32], motion_id_out [63:48],
	// shape_out [71:64], height_front_out [81:72], height_rear_out [91:82]
	output logic [wvs_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	input  logic                              cfg_we,
	input  logic [wvs_pkg::CFG_IX_W-1:0]      cfg_index,
	input  logic [wvs_pkg::CFG_W-1:0]         cfg_wdata
);
	import wvs_pkg::*;

	wvs_cmd_t cmd;
	wvs_sts_t sts;

	wvs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	wvs_dp #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.in_data  (s_axis_tdata),
		.cmd      (cmd),
		.sts      (sts),
		.out_data (m_axis_tdata)
	);

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: windowed velocity smoother testbench
// Drives timestamped velocity commands into the smoother and checks every
// output transaction against a scoreboard that keeps its own history ring,
// running sums and stop flag. A short directed run covers the boundaries,
// then randomised phases sweep the register settings. Each phase uses its
// own pacing on both sides, and one phase stalls the output for a long
// stretch so that the input backs up.
// ----------------------------------------------------------------------------
module tb_top;
	import wvs_pkg::*;

	localparam int HISTORY = 64;
	localparam int PHASES = 8;
	localparam int ITEMS_PER_PHASE = 255;
	localparam int SETTLE_CYCLES = 300;
	localparam int DRAIN_LIMIT = 20000;
	localparam int LONG_HOLD_CYCLES = 400;

	// indexes past the register list, which the block must ignore
	localparam logic [CFG_IX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IX_W-1:0] REG_SPARE_HI = 3'd7;

	typedef logic signed [VEL_W-1:0] vel_t;
	typedef logic [TIME_W-1:0] stamp_t;

	localparam vel_t VEL_MIN = 16'sh8000;
	localparam vel_t VEL_MAX = 16'sh7FFF;

	// output payload, lowest field last
	typedef struct packed {
		logic [3:0]         pad;
		logic [HGT_W-1:0]   height_rear;
		logic [HGT_W-1:0]   height_front;
		logic [SHAPE_W-1:0] shape;
		logic [MID_W-1:0]   gait_code;
		vel_t               avg_yaw;
		vel_t               avg_y;
		vel_t               avg_x;
	} smoothed_cmd_t;

	// scoreboard: windowed mean predictor and queue of expected transactions
	class smoother_scoreboard;
		logic [WIN_W-1:0]   window;
		logic [THR_W-1:0]   threshold;
		logic [MID_W-1:0]   gait_code;
		logic [SHAPE_W-1:0] shape;
		logic [HGT_W-1:0]   hgt_front;
		logic [HGT_W-1:0]   hgt_rear;
		vel_t               ring_x [HISTORY];
		vel_t               ring_y [HISTORY];
		vel_t               ring_yaw [HISTORY];
		stamp_t             ring_t [HISTORY];
		int unsigned        head;
		int unsigned        fill;
		longint             acc_x;
		longint             acc_y;
		longint             acc_yaw;
		bit                 halted;
		smoothed_cmd_t      mean_queue [$];
		int unsigned        errors;

		function new();
			window = RST_WINDOW;
			threshold = RST_THRESHOLD;
			gait_code = RST_MOTION_ID;
			shape = RST_SHAPE;
			hgt_front = RST_HGT_FRONT;
			hgt_rear = RST_HGT_REAR;
			head = 0;
			fill = 0;
			acc_x = 0;
			acc_y = 0;
			acc_yaw = 0;
			halted = 1'b0;
			errors = 0;
		endfunction

		function void write_reg(logic [CFG_IX_W-1:0] ix, logic [CFG_W-1:0] v);
			case (ix)
				REG_WINDOW:    window = v[WIN_W-1:0];
				REG_THRESHOLD: threshold = v[THR_W-1:0];
				REG_MOTION_ID: gait_code = v[MID_W-1:0];
				REG_SHAPE:     shape = v[SHAPE_W-1:0];
				REG_HGT_FRONT: hgt_front = v[HGT_W-1:0];
				REG_HGT_REAR:  hgt_rear = v[HGT_W-1:0];
				default: ;
			endcase
		endfunction

		function bit is_still(vel_t v);
			int m;
			m = v;
			if (m < 0) m = -m;
			return m < int'(threshold);
		endfunction

		function void retire_oldest();
			acc_x -= ring_x[head];
			acc_y -= ring_y[head];
			acc_yaw -= ring_yaw[head];
			head = (head + 1) % HISTORY;
			fill--;
		endfunction

		// one accepted command: update the history and queue the mean it yields
		function void take_command(vel_t x, vel_t y, vel_t w, stamp_t t);
			smoothed_cmd_t r;
			int unsigned slot;
			stamp_t age;
			r = '0;
			r.gait_code = gait_code;
			r.shape = shape;
			r.height_front = hgt_front;
			r.height_rear = hgt_rear;
			if (is_still(x) && is_still(y) && is_still(w)) begin
				// only the first stop of a run produces a zero command
				if (halted) return;
				halted = 1'b1;
			end else begin
				halted = 1'b0;
				age = t - ring_t[head];
				while (fill > 0 && age > stamp_t'(window)) begin
					retire_oldest();
					age = t - ring_t[head];
				end
				if (fill >= HISTORY) retire_oldest();
				slot = (head + fill) % HISTORY;
				ring_x[slot] = x;
				ring_y[slot] = y;
				ring_yaw[slot] = w;
				ring_t[slot] = t;
				fill++;
				acc_x += x;
				acc_y += y;
				acc_yaw += w;
				r.avg_x = vel_t'(acc_x / longint'(fill));
				r.avg_y = vel_t'(acc_y / longint'(fill));
				r.avg_yaw = vel_t'(acc_yaw / longint'(fill));
			end
			mean_queue.insert(mean_queue.size(), r);
		endfunction

		function void check_result(logic [OUT_DATA_W-1:0] data);
			smoothed_cmd_t got;
			smoothed_cmd_t want;
			got = smoothed_cmd_t'(data);
			if (mean_queue.size() == 0) begin
				$error("result transaction with nothing expected: %h", data);
				errors++;
				return;
			end
			want = mean_queue[0];
			mean_queue.delete(0);
			if (got.avg_x !== want.avg_x) begin
				$error("avg_x: expected %0d, got %0d", want.avg_x, got.avg_x);
				errors++;
			end
			if (got.avg_y !== want.avg_y) begin
				$error("avg_y: expected %0d, got %0d", want.avg_y, got.avg_y);
				errors++;
			end
			if (got.avg_yaw !== want.avg_yaw) begin
				$error("avg_yaw: expected %0d, got %0d", want.avg_yaw, got.avg_yaw);
				errors++;
			end
			if (got.gait_code !== want.gait_code) begin
				$error("motion_id_out: expected %0d, got %0d", want.gait_code, got.gait_code);
				errors++;
			end
			if (got.shape !== want.shape) begin
				$error("shape_out: expected %0d, got %0d", want.shape, got.shape);
				errors++;
			end
			if (got.height_front !== want.height_front) begin
				$error("height_front_out: expected %0d, got %0d",
					want.height_front, got.height_front);
				errors++;
			end
			if (got.height_rear !== want.height_rear) begin
				$error("height_rear_out: expected %0d, got %0d",
					want.height_rear, got.height_rear);
				errors++;
			end
		endfunction
	endclass

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic [IN_DATA_W-1:0]      s_axis_tdata = '0;
	logic                      s_axis_tvalid = 1'b0;
	logic                      s_axis_tready;
	logic [OUT_DATA_W-1:0]     m_axis_tdata;
	logic                      m_axis_tvalid;
	logic                      m_axis_tready = 1'b0;
	logic                      cfg_we = 1'b0;
	logic [CFG_IX_W-1:0]       cfg_index = '0;
	logic [CFG_W-1:0]          cfg_wdata = '0;

	smoother_scoreboard sb = new();

	// pacing, set per phase
	int unsigned src_gap_max = 0;
	int unsigned sink_gap_max = 0;
	bit          long_hold = 1'b0;
	int unsigned time_step = 20;
	stamp_t      now_ms = 32'hFFFF_FE00;

	windowed_velocity_smoother #(
		.HISTORY_DEPTH(HISTORY)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// offer one command and wait for its transaction; valid stays high after
	task automatic send_cmd(input vel_t x, input vel_t y, input vel_t w, input stamp_t t);
		int unsigned n;
		n = $urandom_range(0, src_gap_max);
		if (n > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		s_axis_tdata <= {t, w, y, x};
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		sb.take_command(x, y, w, t);
	endtask

	task automatic write_reg(input logic [CFG_IX_W-1:0] ix, input logic [CFG_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_index <= ix;
		cfg_wdata <= v;
		@(posedge clk);
		sb.write_reg(ix, v);
	endtask

	// stop offering, wait for every expected transaction, then let the block settle
	task automatic drain();
		int unsigned waited;
		s_axis_tvalid <= 1'b0;
		waited = 0;
		while (sb.mean_queue.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (sb.mean_queue.size() != 0) begin
			$error("%0d expected results never arrived", sb.mean_queue.size());
			sb.errors++;
			sb.mean_queue.delete();
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// velocity whose magnitude lies under the current stop threshold, zero if it is zero
	function automatic vel_t still_vel();
		int m;
		if (sb.threshold == 0) return '0;
		m = $urandom_range(0, sb.threshold - 1);
		return vel_t'($urandom_range(0, 1) ? -m : m);
	endfunction

	function automatic vel_t pick_vel();
		int m;
		m = sb.threshold;
		case ($urandom_range(0, 9))
			0: return VEL_MIN;
			1: return VEL_MAX;
			2: return vel_t'($urandom_range(0, 1) ? -m : m);
			3, 4: return still_vel();
			default: return vel_t'($urandom());
		endcase
	endfunction

	task automatic send_random();
		int unsigned roll;
		vel_t x;
		vel_t y;
		vel_t w;
		// mostly small forward steps, some big jumps and some going backwards
		roll = $urandom_range(0, 99);
		if (roll < 5)
			now_ms = now_ms + $urandom();
		else if (roll < 9)
			now_ms = now_ms - $urandom_range(1, time_step + 1);
		else
			now_ms = now_ms + $urandom_range(0, time_step);
		if ($urandom_range(0, 3) == 0) begin
			x = still_vel();
			y = still_vel();
			w = still_vel();
		end else begin
			x = pick_vel();
			y = pick_vel();
			w = pick_vel();
		end
		send_cmd(x, y, w, now_ms);
	endtask

	// register settings and pacing of one phase
	task automatic configure_phase(input int p);
		logic [CFG_W-1:0] win;
		logic [CFG_W-1:0] thr;
		case (p)
			0: begin
				// widest window, nothing stops: history fills and evicts
				win = 16'hFFFF;
				thr = 16'h0000;
				write_reg(REG_MOTION_ID, 16'hFFFF);
				write_reg(REG_SHAPE, 16'hFFFF);
				write_reg(REG_HGT_FRONT, 16'hFFFF);
				write_reg(REG_HGT_REAR, 16'hFFFF);
				time_step = 150;
				src_gap_max = 0;
				sink_gap_max = 0;
				long_hold = 1'b1;
			end
			1: begin
				// zero window, largest threshold
				win = 16'h0000;
				thr = 16'h7FFF;
				write_reg(REG_MOTION_ID, 16'h0000);
				write_reg(REG_SHAPE, 16'h0000);
				write_reg(REG_HGT_FRONT, 16'h0000);
				write_reg(REG_HGT_REAR, 16'h0000);
				time_step = 1;
				src_gap_max = 14;
				sink_gap_max = 14;
			end
			2: begin
				win = 16'h0001;
				thr = 16'h8001;
				write_reg(REG_MOTION_ID, 16'($urandom()));
				write_reg(REG_SHAPE, 16'($urandom()));
				time_step = 2;
				src_gap_max = 14;
				sink_gap_max = 0;
			end
			3: begin
				win = 16'h0000;
				thr = 16'h0000;
				time_step = 1;
				src_gap_max = 0;
				sink_gap_max = 14;
			end
			default: begin
				win = 16'($urandom_range(1, 3000));
				thr = {1'($urandom()), 15'($urandom_range(0, 400))};
				write_reg(REG_MOTION_ID, 16'($urandom()));
				write_reg(REG_SHAPE, 16'($urandom()));
				write_reg(REG_HGT_FRONT, 16'($urandom()));
				write_reg(REG_HGT_REAR, 16'($urandom()));
				time_step = win / 12 + 1;
				src_gap_max = $urandom_range(0, 1) * 14;
				sink_gap_max = $urandom_range(0, 1) * 14;
			end
		endcase
		write_reg(REG_WINDOW, win);
		write_reg(REG_THRESHOLD, thr);
		write_reg(REG_SPARE_LO, 16'($urandom()));
		write_reg(REG_SPARE_HI, 16'($urandom()));
		cfg_we <= 1'b0;
	endtask

	// output side: random stalls, one long hold-off when asked for
	initial begin : output_sink
		int unsigned n;
		@(posedge arst_n);
		forever begin
			if (long_hold) begin
				long_hold = 1'b0;
				n = LONG_HOLD_CYCLES;
			end else begin
				n = $urandom_range(0, sink_gap_max);
			end
			if (n > 0) begin
				m_axis_tready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			sb.check_result(m_axis_tdata);
		end
	end

	initial begin : stimulus
		int p;
		int i;
		stamp_t t0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed run on the reset settings: window 500, threshold 5
		t0 = 32'hFFFF_FE00;
		src_gap_max = 3;
		sink_gap_max = 3;
		send_cmd(16'sd0, 16'sd0, 16'sd0, t0);             // first stop gives zeros
		send_cmd(16'sd4, -16'sd4, -16'sd4, t0 + 10);      // repeated stop, silent
		send_cmd(16'sd5, 16'sd0, 16'sd0, t0 + 20);        // magnitude equal to threshold
		send_cmd(-16'sd5, 16'sd4, 16'sd0, t0 + 30);
		send_cmd(VEL_MAX, VEL_MIN, VEL_MAX, t0 + 40);
		send_cmd(VEL_MIN, VEL_MIN, VEL_MIN, t0 + 50);     // x and yaw sums of -1 truncate to zero
		send_cmd(-16'sd1, 16'sd2, -16'sd3, t0 + 60);      // stop keeps the history
		send_cmd(-16'sd1, 16'sd2, -16'sd3, t0 + 70);
		send_cmd(16'sd100, -16'sd7, 16'sd33, t0 + 80);
		send_cmd(16'sd7, -16'sd7, 16'sd6, t0 + 600);      // time wraps, old entries age out
		send_cmd(16'sd9, 16'sd9, 16'sd9, t0 + 500);       // timestamp goes backwards
		send_cmd(-16'sd9, 16'sd0, 16'sd0, t0 + 1000);     // age exactly the window, kept
		send_cmd(16'sd0, 16'sd0, VEL_MIN, t0 + 1001);     // one past the window, dropped
		send_cmd(16'sd0, 16'sd0, 16'sd0, t0 + 1002);
		send_cmd(16'sd3, 16'sd3, 16'sd3, t0 + 1003);
		send_cmd(16'sd0, 16'sd0, 16'sd6, t0 + 1004);
		send_cmd(-16'sd32767, 16'sd1, VEL_MAX, t0 + 1004);
		now_ms = t0 + 1004;
		drain();

		for (p = 0; p < PHASES; p++) begin
			configure_phase(p);
			for (i = 0; i < ITEMS_PER_PHASE; i++)
				send_random();
			drain();
		end

		if (sb.errors == 0)
			$display("** windowed_velocity_smoother: PASSED **");
		else
			$display("** windowed_velocity_smoother: FAILED **");
		$finish;
	end

	// run limit, well beyond the slowest legal run
	initial begin : watchdog
		#20_000_000;
		$display("** windowed_velocity_smoother: FAILED **");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+rtl
rtl/wvs_pkg.sv
rtl/wvs_div.sv
rtl/wvs_ctrl.sv
rtl/wvs_dp.sv
rtl/windowed_velocity_smoother.sv
tb/tb_top.sv
